// File: hdl/assert_macros.svh
// Assertion helpers for concurrent checks clocked on clk, held off during arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CHK_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define CHK_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define CHK_ALWAYS(label, cond, msg)

`define CHK_IMPLY(label, ante, cons, msg)

`endif

`endif

// File: hdl/b64ac_pkg.sv
package b64ac_pkg;

	localparam logic [1:0] PH_MARKER  = 2'd0;
	localparam logic [1:0] PH_ANCHOR  = 2'd1;
	localparam logic [1:0] PH_CAPTURE = 2'd2;
	localparam logic [1:0] PH_DONE    = 2'd3;

	localparam logic [1:0] KIND_BYTE      = 2'd0;
	localparam logic [1:0] KIND_END_RUN   = 2'd1;
	localparam logic [1:0] KIND_NO_ANCHOR = 2'd2;

	localparam int          MARKER_LEN    = 20;
	localparam int          ANCHOR_LEN    = 4;
	localparam int          MAX_RESULTS   = 4;
	localparam int          FIFO_DEPTH    = 16;
	localparam logic [9:0]  CAP_LEN_RESET = 10'd600;
	localparam logic [3:0]  BCNT_START    = 4'b1000;
	localparam logic [7:0]  CH_QUOTE      = 8'h22;
	localparam logic [4:0]  LEVEL_LIMIT   = 5'(FIFO_DEPTH - 2 * MAX_RESULTS);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [2:0]                 n;
		res_t [MAX_RESULTS-1:0]     item;
	} burst_t;

	function automatic logic [7:0] marker_char(input logic [4:0] idx);
		logic [7:0] c;
		case (idx)
			5'd0:    c = 8'h22;
			5'd1:    c = "h";
			5'd2:    c = "t";
			5'd3:    c = "t";
			5'd4:    c = "p";
			5'd5:    c = "R";
			5'd6:    c = "e";
			5'd7:    c = "s";
			5'd8:    c = "p";
			5'd9:    c = "o";
			5'd10:   c = "n";
			5'd11:   c = "s";
			5'd12:   c = "e";
			5'd13:   c = "B";
			5'd14:   c = "o";
			5'd15:   c = "d";
			5'd16:   c = "y";
			5'd17:   c = 8'h22;
			5'd18:   c = ":";
			5'd19:   c = 8'h22;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] anchor_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0:    c = "<";
			2'd1:    c = "h";
			2'd2:    c = "1";
			default: c = ">";
		endcase
		return c;
	endfunction

	// {valid, value}
	function automatic logic [6:0] b64_value(input logic [7:0] ch);
		logic [6:0] r;
		r = 7'd0;
		if (ch >= "A" && ch <= "Z")
			r = {1'b1, 6'(ch - 8'd65)};
		else if (ch >= "a" && ch <= "z")
			r = {1'b1, 6'(ch - 8'd71)};
		else if (ch >= "0" && ch <= "9")
			r = {1'b1, 6'(ch + 8'd4)};
		else if (ch == "+")
			r = {1'b1, 6'd62};
		else if (ch == "/")
			r = {1'b1, 6'd63};
		return r;
	endfunction

endpackage

// File: hdl/b64ac_core.sv
module b64ac_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [9:0]      cfg_data,
	input  logic            item_valid,
	input  logic            item_restart,
	input  logic [7:0]      item_char,
	output b64ac_pkg::burst_t burst
);
	import b64ac_pkg::*;

	logic [1:0]  phase_q, phase_d;
	logic [4:0]  match_q, match_d;
	logic [11:0] acc_q, acc_d;
	logic [3:0]  bcnt_q, bcnt_d;
	logic [9:0]  count_q, count_d;
	logic [9:0]  cap_len_q;

	logic [4:0]  mi;
	logic [2:0]  ai;
	logic [6:0]  bv;
	logic [11:0] acc_new;
	logic [4:0]  bsum;
	logic [4:0]  bsub;
	logic [7:0]  dbyte;
	logic [9:0]  cnt_inc;
	logic        short_run;

	always_comb begin
		phase_d   = phase_q;
		match_d   = match_q;
		acc_d     = acc_q;
		bcnt_d    = bcnt_q;
		count_d   = count_q;
		burst     = '0;
		mi        = (match_q < 5'(MARKER_LEN)) ? match_q : 5'd0;
		ai        = (match_q < 5'(ANCHOR_LEN)) ? match_q[2:0] : 3'd0;
		bv        = b64_value(item_char);
		acc_new   = {acc_q[5:0], bv[5:0]};
		bsum      = {bcnt_q[3], bcnt_q} + 5'd6;
		bsub      = bsum - 5'd8;
		dbyte     = 8'(acc_new >> bsum[2:0]);
		cnt_inc   = count_q + 10'd1;
		short_run = cap_len_q <= 10'(ANCHOR_LEN);
		if (item_valid) begin
			if (item_restart) begin
				phase_d = PH_MARKER;
				match_d = '0;
				acc_d   = '0;
				bcnt_d  = BCNT_START;
				count_d = '0;
			end else begin
				case (phase_q)
					PH_MARKER: begin
						if (item_char == marker_char(mi))
							mi = mi + 5'd1;
						else
							mi = (item_char == marker_char(5'd0)) ? 5'd1 : 5'd0;
						if (mi == 5'(MARKER_LEN)) begin
							phase_d = PH_ANCHOR;
							match_d = '0;
							acc_d   = '0;
							bcnt_d  = BCNT_START;
						end else begin
							match_d = mi;
						end
					end
					PH_DONE: begin
					end
					default: begin
						if (item_char == CH_QUOTE) begin
							burst.n            = 3'd1;
							burst.item[0].kind = (phase_q == PH_ANCHOR) ? KIND_NO_ANCHOR
								: KIND_END_RUN;
							burst.item[0].last = 1'b1;
							phase_d            = PH_DONE;
						end else if (bv[6]) begin
							acc_d = acc_new;
							if (!bsum[4]) begin
								bcnt_d = bsub[3:0];
								if (phase_q == PH_ANCHOR) begin
									if (dbyte == anchor_char(ai[1:0]))
										ai = ai + 3'd1;
									else
										ai = (dbyte == anchor_char(2'd0)) ? 3'd1 : 3'd0;
									match_d = {2'b00, ai};
									if (ai == 3'(ANCHOR_LEN)) begin
										burst.n = 3'(ANCHOR_LEN);
										for (int k = 0; k < ANCHOR_LEN; k++) begin
											burst.item[k].kind      = KIND_BYTE;
											burst.item[k].data_byte = anchor_char(2'(k));
										end
										burst.item[ANCHOR_LEN-1].last = short_run;
										count_d = 10'(ANCHOR_LEN);
										match_d = '0;
										phase_d = short_run ? PH_DONE : PH_CAPTURE;
									end
								end else begin
									count_d                 = cnt_inc;
									burst.n                 = 3'd1;
									burst.item[0].kind      = KIND_BYTE;
									burst.item[0].data_byte = dbyte;
									burst.item[0].last      = cnt_inc >= cap_len_q;
									if (cnt_inc >= cap_len_q)
										phase_d = PH_DONE;
								end
							end else begin
								bcnt_d = bsum[3:0];
							end
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_MARKER;
			match_q   <= '0;
			acc_q     <= '0;
			bcnt_q    <= BCNT_START;
			count_q   <= '0;
			cap_len_q <= CAP_LEN_RESET;
		end else begin
			phase_q <= phase_d;
			match_q <= match_d;
			acc_q   <= acc_d;
			bcnt_q  <= bcnt_d;
			count_q <= count_d;
			if (cfg_we)
				cap_len_q <= cfg_data;
		end
	end

endmodule

// File: hdl/b64ac_fifo.sv
module b64ac_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  b64ac_pkg::burst_t push,
	input  logic              pop,
	output b64ac_pkg::res_t   head,
	output logic              not_empty,
	output logic [4:0]        level
);
	import b64ac_pkg::*;

	res_t       mem_q [FIFO_DEPTH];
	logic [3:0] wr_ptr_q;
	logic [3:0] rd_ptr_q;
	logic [4:0] level_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = level_q != 5'd0;
	assign level     = level_q;

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RESULTS; k++) begin
			if (3'(k) < push.n)
				mem_q[wr_ptr_q + 4'(k)] <= push.item[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + {1'b0, push.n};
			rd_ptr_q <= rd_ptr_q + {3'b000, pop};
			level_q  <= level_q + {2'b00, push.n} - {4'b0000, pop};
		end
	end

endmodule

// File: hdl/base64_stream_anchor_capture.sv
// Response-stream base64 anchor capture.
// s_*: one raw character per transfer; s_tuser[0] = restart (character ignored,
//   block returns to field-marker search). Accepted on s_tvalid & s_tready.
// m_*: one result per transfer: m_tdata = decoded byte (zero unless kind is 0),
//   m_tuser = kind (0 byte, 1 field ended in capture, 2 field ended before
//   anchor), m_tlast = final result of the capture run.
// cfg_*: run length write (total bytes per run, anchor included), always ready;
//   write only while the block is idle.
// Throughput: one character per cycle while s_tready is high. Each character is
//   registered, decoded and its results written to the result queue. The anchor
//   pushes four results at once; they leave one per cycle while m_tready is high.
// s_tready is set by the fill level of the 16-entry result queue: it stays high
//   while at most 8 entries are held, so a stalled receiver backs the queue up
//   and then stops input; nothing is dropped.
// Reset: field-marker search, decoder cleared, run length = 600, queue empty.
module base64_stream_anchor_capture (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] raw_char
	input  logic [0:0] s_tuser,   // [0] restart
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] data_byte
	output logic [1:0] m_tuser,   // [1:0] kind
	output logic       m_tlast,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [9:0] cfg_data
);
	import b64ac_pkg::*;

	`include "assert_macros.svh"

	logic       vld_s1;
	logic       restart_s1;
	logic [7:0] char_s1;
	burst_t     burst;
	res_t       head;
	logic [4:0] level;
	logic       s_xfer;

	assign cfg_ready = 1'b1;
	assign s_tready  = level <= LEVEL_LIMIT;
	assign s_xfer    = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= s_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			restart_s1 <= s_tuser[0];
			char_s1    <= s_tdata;
		end
	end

	b64ac_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_data     (cfg_data),
		.item_valid   (vld_s1),
		.item_restart (restart_s1),
		.item_char    (char_s1),
		.burst        (burst)
	);

	b64ac_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (burst),
		.pop       (m_tvalid & m_tready),
		.head      (head),
		.not_empty (m_tvalid),
		.level     (level)
	);

	assign m_tdata = head.data_byte;
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

	`CHK_ALWAYS(a_level_bound, level <= 5'(FIFO_DEPTH), "result queue overflow")
	`CHK_IMPLY(a_burst_size, vld_s1 && burst.n > 3'd1, burst.n == 3'(ANCHOR_LEN), "bad burst size")
	`CHK_IMPLY(a_end_kind, m_tvalid && m_tuser != KIND_BYTE, m_tdata == 8'd0 && m_tlast, "end result")
	`CHK_IMPLY(a_no_input_when_restart, vld_s1 && restart_s1, burst.n == 3'd0, "result on restart")

endmodule
